// File: rtl/core/zatr_pkg.sv
// ----------------------------------------------------------------------------
// zatr_pkg: shared types and constants
// Widths, register addresses and controller types for the ATR entry filter.
// ----------------------------------------------------------------------------
package zatr_pkg;

  localparam int MAX_PERIOD    = 64;
  localparam int MEDIAN_WINDOW = 31;
  localparam int PRICE_BITS    = 32;

  localparam int RING_AW  = $clog2(MAX_PERIOD);
  localparam int WIN_AW   = $clog2(MEDIAN_WINDOW);
  localparam int CNT_W    = $clog2(MAX_PERIOD + 1);
  localparam int WCNT_W   = $clog2(MEDIAN_WINDOW + 1);
  localparam int SUM_W    = PRICE_BITS + RING_AW;

  localparam logic [1:0] ADDR_THRESH = 2'd0;
  localparam logic [1:0] ADDR_MULT   = 2'd1;
  localparam logic [1:0] ADDR_PERIOD = 2'd2;

  localparam logic [1:0] VERDICT_ENTER = 2'd0;
  localparam logic [1:0] VERDICT_INVAL = 2'd1;
  localparam logic [1:0] VERDICT_ZHIGH = 2'd2;
  localparam logic [1:0] VERDICT_VOL   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TR,
    ST_SUM,
    ST_DIV,
    ST_MED,
    ST_QRY,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;      // capture input transaction
    logic tr_write;  // compute true range and write the ring
    logic sum_step;  // accumulate one ring entry
    logic div_start;
    logic div_step;
    logic win_write; // store the new ATR
    logic med_start;
    logic med_step;
    logic qry_eval;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic has_prev;
    logic sum_done;
    logic div_done;
    logic med_done;
  } sts_t;

endpackage

// File: rtl/core/zscore_entry_atr_regime_filter.sv
// ----------------------------------------------------------------------------
// zscore_entry_atr_regime_filter: z-score entry with ATR regime filter
// Pushes bars into an ATR and median tracker and answers entry queries.
// ----------------------------------------------------------------------------
// Channel | Handshake          | Payload
// in      | in_valid/in_stall  | func, bar_*, query_close, vwap_value, stdev_value
// out     | out_valid/out_stall| enter, verdict, atr_value, median_value
// cfg     | APB write/read     | zscore_threshold, vol_mult, avg_period
//
// One transaction is in work at a time. A query runs the median rank search,
// which scans all n stored ATRs for each candidate it tries, then the query
// evaluation and output states. A push with a previous bar adds window
// summing and division before the search. Reset is synchronous and needs no
// clearing pass. A stalled result keeps the controller in its output state
// once the next transaction reaches it.
module zscore_entry_atr_regime_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [31:0] bar_high,
  input  logic [31:0] bar_low,
  input  logic [31:0] bar_close,
  input  logic [31:0] query_close,
  input  logic [31:0] vwap_value,
  input  logic [31:0] stdev_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        enter,
  output logic [1:0]  verdict,
  output logic [31:0] atr_value,
  output logic [31:0] median_value
);

  logic [15:0] zscore_threshold, vol_mult;
  logic [6:0]  avg_period;
  zatr_pkg::cmd_t cmd;
  zatr_pkg::sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zscore_threshold <= 16'd512;
      vol_mult         <= 16'd0;
      avg_period       <= 7'd14;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        zatr_pkg::ADDR_THRESH: zscore_threshold <= pwdata[15:0];
        zatr_pkg::ADDR_MULT:   vol_mult         <= pwdata[15:0];
        zatr_pkg::ADDR_PERIOD: avg_period       <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      zatr_pkg::ADDR_THRESH: prdata = {16'd0, zscore_threshold};
      zatr_pkg::ADDR_MULT:   prdata = {16'd0, vol_mult};
      zatr_pkg::ADDR_PERIOD: prdata = {25'd0, avg_period};
      default:               prdata = 32'd0;
    endcase
  end

  zatr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  zatr_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .zscore_threshold (zscore_threshold),
    .vol_mult         (vol_mult),
    .avg_period       (avg_period),
    .func             (func),
    .bar_high         (bar_high),
    .bar_low          (bar_low),
    .bar_close        (bar_close),
    .query_close      (query_close),
    .vwap_value       (vwap_value),
    .stdev_value      (stdev_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .enter            (enter),
    .verdict          (verdict),
    .atr_value        (atr_value),
    .median_value     (median_value)
  );

endmodule

// File: rtl/core/zatr_ctrl.sv
// ----------------------------------------------------------------------------
// zatr_ctrl: sequencing controller
// Steps a push through true range, window sum, division and median search.
// ----------------------------------------------------------------------------
module zatr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             out_valid,
  input  logic             out_stall,
  input  zatr_pkg::sts_t   sts,
  output zatr_pkg::cmd_t   cmd
);

  zatr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= zatr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = rst || (state != zatr_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      zatr_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = zatr_pkg::ST_TR;
        end
      end
      zatr_pkg::ST_TR: begin
        if (sts.func) begin
          cmd.med_start = 1'b1;
          state_next = zatr_pkg::ST_MED;
        end else if (sts.has_prev) begin
          cmd.tr_write = 1'b1;
          state_next = zatr_pkg::ST_SUM;
        end else begin
          cmd.med_start = 1'b1;
          state_next = zatr_pkg::ST_MED;
        end
      end
      zatr_pkg::ST_SUM: begin
        if (sts.sum_done) begin
          cmd.div_start = 1'b1;
          state_next = zatr_pkg::ST_DIV;
        end else begin
          cmd.sum_step = 1'b1;
        end
      end
      zatr_pkg::ST_DIV: begin
        if (sts.div_done) begin
          cmd.win_write = 1'b1;
          cmd.med_start = 1'b1;
          state_next = zatr_pkg::ST_MED;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      zatr_pkg::ST_MED: begin
        if (sts.med_done) begin
          state_next = zatr_pkg::ST_QRY;
        end else begin
          cmd.med_step = 1'b1;
        end
      end
      zatr_pkg::ST_QRY: begin
        cmd.qry_eval = 1'b1;
        state_next = zatr_pkg::ST_OUT;
      end
      zatr_pkg::ST_OUT: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next = zatr_pkg::ST_IDLE;
        end
      end
      default: state_next = zatr_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: rtl/core/zatr_datapath.sv
// ----------------------------------------------------------------------------
// zatr_datapath: ATR and entry datapath
// True range ring, window sum, restoring divider, median rank search and
// the entry comparisons.
// ----------------------------------------------------------------------------
module zatr_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  zatr_pkg::cmd_t                      cmd,
  output zatr_pkg::sts_t                      sts,
  input  logic [15:0]                         zscore_threshold,
  input  logic [15:0]                         vol_mult,
  input  logic [6:0]                          avg_period,
  input  logic                                func,
  input  logic [zatr_pkg::PRICE_BITS-1:0]     bar_high,
  input  logic [zatr_pkg::PRICE_BITS-1:0]     bar_low,
  input  logic [zatr_pkg::PRICE_BITS-1:0]     bar_close,
  input  logic [zatr_pkg::PRICE_BITS-1:0]     query_close,
  input  logic [zatr_pkg::PRICE_BITS-1:0]     vwap_value,
  input  logic [zatr_pkg::PRICE_BITS-1:0]     stdev_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                enter,
  output logic [1:0]                          verdict,
  output logic [31:0]                         atr_value,
  output logic [31:0]                         median_value
);

  localparam int PB = zatr_pkg::PRICE_BITS;
  localparam int SW = zatr_pkg::SUM_W;
  localparam int RA = zatr_pkg::RING_AW;
  localparam int WA = zatr_pkg::WIN_AW;
  localparam int CW = zatr_pkg::CNT_W;
  localparam int WC = zatr_pkg::WCNT_W;
  localparam int DSTEPS = SW;
  localparam int DCW = $clog2(DSTEPS + 1);

  // Captured transaction.
  logic          r_func;
  logic [PB-1:0] r_high, r_low, r_close, r_qclose, r_vwap, r_sd;

  // Persistent state.
  logic [PB-1:0] previous_close;
  logic [15:0]   bar_count;
  logic [RA-1:0] ring_head;
  logic [CW-1:0] ring_fill;
  logic [WA-1:0] win_head;
  logic [WC-1:0] win_fill;
  logic [PB-1:0] current_atr;

  logic [PB-1:0] range_ring [zatr_pkg::MAX_PERIOD];
  logic [PB-1:0] atr_window [zatr_pkg::MEDIAN_WINDOW];

  // True range.
  logic [PB-1:0] hl, t2, t3, tr;
  always_comb begin
    hl = (r_high >= r_low) ? r_high - r_low : '0;
    t2 = (r_high >= previous_close) ? r_high - previous_close : previous_close - r_high;
    t3 = (r_low >= previous_close) ? r_low - previous_close : previous_close - r_low;
    tr = hl;
    if (t2 > tr) tr = t2;
    if (t3 > tr) tr = t3;
  end

  // Effective period clamp.
  logic [CW-1:0] period_eff;
  always_comb begin
    if (avg_period == '0) begin
      period_eff = CW'(1);
    end else if ({1'b0, avg_period} > 8'(zatr_pkg::MAX_PERIOD)) begin
      period_eff = CW'(zatr_pkg::MAX_PERIOD);
    end else begin
      period_eff = CW'(avg_period);
    end
  end

  // Window sum over the ring, one entry per cycle via a registered read.
  logic [CW-1:0] sum_k, sum_issued, sum_got;
  logic [RA-1:0] rd_addr;
  logic [PB-1:0] rd_data;
  logic          rd_valid;
  logic [SW-1:0] range_sum;

  assign sts.sum_done = (sum_got == sum_k) && !rd_valid;

  always_ff @(posedge clk) begin
    if (cmd.tr_write) begin
      range_ring[ring_head] <= tr;
    end
    rd_data <= range_ring[rd_addr];
  end

  always_comb begin
    rd_addr = ring_head - RA'(1) - sum_issued[RA-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.sum_step && (sum_issued < sum_k);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tr_write) begin
      sum_issued <= '0;
      sum_got    <= '0;
      range_sum  <= '0;
      sum_k      <= (period_eff < ring_fill + CW'(1)) ? period_eff :
                    ((ring_fill == CW'(zatr_pkg::MAX_PERIOD)) ? ring_fill
                                                               : ring_fill + CW'(1));
    end else if (cmd.sum_step) begin
      if (sum_issued < sum_k) sum_issued <= sum_issued + CW'(1);
      if (rd_valid) begin
        range_sum <= range_sum + SW'(rd_data);
        sum_got   <= sum_got + CW'(1);
      end
    end
  end

  // Restoring divider: range_sum / sum_k, one quotient bit per cycle.
  logic [SW-1:0]  quo;
  logic [CW:0]    rem;
  logic [DCW-1:0] dcnt;
  logic [CW:0]    rem_sh;
  assign rem_sh = {rem[CW-1:0], quo[SW-1]};
  assign sts.div_done = (dcnt == DCW'(DSTEPS));

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo  <= range_sum;
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, sum_k}) begin
        rem <= rem_sh - {1'b0, sum_k};
        quo <= {quo[SW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[SW-2:0], 1'b0};
      end
      dcnt <= dcnt + DCW'(1);
    end
  end

  // Median by rank: for each candidate, count smaller and not-greater
  // entries; the upper median is the one whose rank window covers n/2.
  logic [WA-1:0] cand, scan;
  logic [PB-1:0] cand_val, scan_val;
  logic [WC-1:0] n_less, n_le;
  logic          med_found, scan_phase;
  logic [PB-1:0] med_val;
  logic [WC-1:0] half;
  logic          med_active;
  logic          enough_bars;
  assign half = win_fill >> 1;

  // A push counts its own bar, which is added at the same edge.
  assign enough_bars = r_func ? (bar_count >= 16'd3) : (bar_count >= 16'd2);

  always_ff @(posedge clk) begin
    if (cmd.win_write) begin
      atr_window[win_head] <= quo[PB-1:0];
    end
    cand_val <= atr_window[cand];
    scan_val <= atr_window[scan];
  end

  // Two read ports: the candidate value follows the candidate pointer, the scan
  // pointer walks all filled entries.
  logic [WC-1:0] scan_cnt;
  always_ff @(posedge clk) begin
    if (rst) begin
      med_active <= 1'b0;
      med_found  <= 1'b0;
    end else if (cmd.med_start) begin
      med_active <= enough_bars && (win_fill != '0 || cmd.win_write);
      med_found  <= 1'b0;
    end else if (cmd.med_step && med_active) begin
      if (scan_phase && scan_cnt == win_fill + WC'(1)) begin
        if (n_less <= half && half < n_le) begin
          med_found  <= 1'b1;
          med_active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.med_start) begin
      cand       <= '0;
      scan       <= '0;
      scan_cnt   <= '0;
      scan_phase <= 1'b0;
      n_less     <= '0;
      n_le       <= '0;
      med_val    <= '0;
    end else if (cmd.med_step && med_active) begin
      if (!scan_phase) begin
        // cand_val becomes valid on the next edge.
        scan_phase <= 1'b1;
        scan       <= WA'(1);
        scan_cnt   <= WC'(1);
      end else if (scan_cnt == win_fill + WC'(1)) begin
        med_val    <= cand_val;
        cand       <= cand + WA'(1);
        scan       <= '0;
        scan_cnt   <= '0;
        scan_phase <= 1'b0;
        n_less     <= '0;
        n_le       <= '0;
      end else begin
        if (scan_val < cand_val)  n_less <= n_less + WC'(1);
        if (scan_val <= cand_val) n_le   <= n_le + WC'(1);
        scan     <= scan + WA'(1);
        scan_cnt <= scan_cnt + WC'(1);
      end
    end
  end

  assign sts.med_done = !med_active && !cmd.med_start;

  logic [PB-1:0] median;
  assign median = med_found ? med_val : '0;

  // Persistent state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_close <= '0;
      bar_count      <= '0;
      ring_head      <= '0;
      ring_fill      <= '0;
      win_head       <= '0;
      win_fill       <= '0;
      current_atr    <= '0;
    end else begin
      if (cmd.tr_write) begin
        ring_head <= ring_head + RA'(1);
        if (ring_fill != CW'(zatr_pkg::MAX_PERIOD)) ring_fill <= ring_fill + CW'(1);
      end
      if (cmd.win_write) begin
        current_atr <= quo[PB-1:0];
        win_head    <= (win_head == WA'(zatr_pkg::MEDIAN_WINDOW - 1)) ? '0
                                                                      : win_head + WA'(1);
        if (win_fill != WC'(zatr_pkg::MEDIAN_WINDOW)) win_fill <= win_fill + WC'(1);
      end
      if (cmd.med_start && !r_func) begin
        previous_close <= r_close;
        if (bar_count != 16'hFFFF) bar_count <= bar_count + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_func   <= func;
      r_high   <= bar_high;
      r_low    <= bar_low;
      r_close  <= bar_close;
      r_qclose <= query_close;
      r_vwap   <= vwap_value;
      r_sd     <= stdev_value;
    end
  end

  assign sts.func     = r_func;
  assign sts.has_prev = (bar_count != '0);

  // Query products, one multiplier stage.
  logic [PB+7:0]  z_lhs;
  logic [PB+15:0] z_rhs;
  logic [PB+7:0]  v_lhs;
  logic [PB+15:0] v_rhs;
  logic           z_ok, v_bad;
  logic [1:0]     verd;

  // The difference is only meaningful when close is at or below vwap.
  assign z_lhs = {r_vwap - r_qclose, 8'd0};
  assign z_rhs = (PB+16)'(zscore_threshold) * (PB+16)'(r_sd);
  assign v_lhs = {current_atr, 8'd0};
  assign v_rhs = (PB+16)'(vol_mult) * (PB+16)'(median);

  always_ff @(posedge clk) begin
    if (cmd.qry_eval) begin
      z_ok  <= (r_qclose <= r_vwap) && ((PB+16)'(z_lhs) >= z_rhs);
      v_bad <= (vol_mult != '0) && (median != '0) && ((PB+16)'(v_lhs) > v_rhs);
    end
  end

  always_comb begin
    if (!r_func) verd = zatr_pkg::VERDICT_ENTER;
    else if (r_vwap == '0 || r_sd == '0) verd = zatr_pkg::VERDICT_INVAL;
    else if (!z_ok) verd = zatr_pkg::VERDICT_ZHIGH;
    else if (v_bad) verd = zatr_pkg::VERDICT_VOL;
    else verd = zatr_pkg::VERDICT_ENTER;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      verdict      <= verd;
      enter        <= r_func && (verd == zatr_pkg::VERDICT_ENTER);
      atr_value    <= 32'(current_atr);
      median_value <= 32'(median);
    end
  end

endmodule
